// File: rtl/core/rssd_pkg.sv
// Shared constants, types and state codes for the rolling sample deviation block.
`timescale 1ns / 1ps
package rssd_pkg;

   localparam int WINDOW_MAX   = 64;
   localparam int SAMPLE_WIDTH = 32;
   localparam int DEV_W        = 32;
   localparam int LEN_W        = 7;
   localparam int ADDR_W       = $clog2(WINDOW_MAX);
   localparam int LOG_W        = $clog2(WINDOW_MAX);
   localparam int S1_W         = SAMPLE_WIDTH + LOG_W + 1;
   localparam int SQ_W         = 2 * SAMPLE_WIDTH;
   localparam int S2_W         = SQ_W + LOG_W;
   localparam int NUM_W        = S2_W + LEN_W;
   localparam int D_W          = 2 * LEN_W;
   localparam int RAD_W        = 2 * DEV_W;
   localparam int CNT_W        = $clog2(NUM_W + WINDOW_MAX + 1);
   localparam int RAM_W        = SAMPLE_WIDTH + 1;

   localparam int CSR_ADDR_W = 3;
   localparam logic REG_WINDOW_LENGTH = 1'b0;
   localparam logic [LEN_W-1:0] WINDOW_LENGTH_RESET = LEN_W'(20);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_DRAIN,
      ST_MUL_A,
      ST_MUL_B,
      ST_DIV,
      ST_ROOT_INIT,
      ST_ROOT,
      ST_DONE
   } rssd_state_type;

   typedef struct packed {
      logic              start;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_idx;
      logic              mul_load_a;
      logic              mul_load_b;
      logic              mul_step;
      logic              div_load;
      logic              div_step;
      logic              sqrt_load;
      logic              sqrt_step;
      logic              out_load;
   } rssd_cmd_type;

   typedef struct packed {
      logic             enough;
      logic             pipe_busy;
      logic             mul_done;
      logic             out_free;
      logic [LEN_W-1:0] len;
   } rssd_status_type;

endpackage

// File: rtl/core/rssd_chan_if.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface rssd_req_if;
   import rssd_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [SAMPLE_WIDTH-1:0] sample_value;
   logic                    sample_valid;
   logic                    series_start;
   modport source (output valid, sample_value, sample_valid, series_start, input ready);
   modport sink (input valid, sample_value, sample_valid, series_start, output ready);
endinterface

interface rssd_rsp_if;
   import rssd_pkg::*;
   logic             valid;
   logic             ready;
   logic [DEV_W-1:0] deviation_value;
   logic             result_valid;
   modport source (output valid, deviation_value, result_valid, input ready);
   modport sink (input valid, deviation_value, result_valid, output ready);
endinterface

// File: rtl/core/rolling_sample_std_dev.sv
// Top level of the moving-window sample standard deviation block.
// Each sample word is written into a 64-entry window RAM and answered by one
// result word: the sample standard deviation of the last N samples (N from
// window_length, clamped to 2..64), unsigned Q16.16, rounded down, saturated;
// result_valid is 0 (and the value 0) until N samples of the series are held
// and all of them are marked valid. Each word runs through N reads of the RAM
// through the single read port, a drain of the read pipeline, two bit-serial
// multiply passes (S2 times N, then |S1| squared), a restoring divide and a
// square root, plus the accept, start, root set-up and hand-off steps. A word
// that arrives before N samples of the series are held skips the scan and the
// arithmetic. A finished result waits in an output register while the next
// sample is taken.
`timescale 1ns / 1ps
module rolling_sample_std_dev (
   input  logic                              clock,
   input  logic                              reset,
   rssd_req_if.sink                          req_chan,
   rssd_rsp_if.source                        rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rssd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import rssd_pkg::*;

   logic [LEN_W-1:0] window_length_ff;
   rssd_cmd_type     cmd;
   rssd_status_type  status;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_LENGTH_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr[2] == REG_WINDOW_LENGTH) begin
         window_length_ff <= csr_pwdata[LEN_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_WINDOW_LENGTH)
                       ? {{(32-LEN_W){1'b0}}, window_length_ff} : 32'd0;

   rssd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rssd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .window_length   (window_length_ff),
      .sample_value    (req_chan.sample_value),
      .sample_valid    (req_chan.sample_valid),
      .series_start    (req_chan.series_start),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .deviation_value (rsp_chan.deviation_value),
      .result_valid    (rsp_chan.result_valid)
   );

   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("word accepted while the previous one is in progress");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.result_valid) |-> rsp_chan.deviation_value == '0)
      else $error("invalid result carries a nonzero deviation");

   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result register overwritten before it was taken");

   assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> (status.len >= LEN_W'(2) && status.len <= LEN_W'(WINDOW_MAX)))
      else $error("window scan with an out-of-range length");
endmodule

// File: rtl/core/rssd_ram.sv
// Generic single write, single read RAM with registered read data.
`timescale 1ns / 1ps
module rssd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// File: rtl/core/rssd_ctrl.sv
// Sequencer: scan, multiply, divide, root and result hand-off.
`timescale 1ns / 1ps
module rssd_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  rssd_pkg::rssd_status_type status,
   output rssd_pkg::rssd_cmd_type    cmd
);
   import rssd_pkg::*;

   rssd_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] len_last;

   assign len_last = CNT_W'(status.len) - CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            cnt_in   = '0;
            state_in = status.enough ? ST_SCAN : ST_DONE;
         end
         ST_SCAN: begin
            if (cnt_ff == len_last) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            if (status.mul_done) begin
               state_in = ST_MUL_B;
            end
         end
         ST_MUL_B: begin
            if (status.mul_done) begin
               state_in = ST_DIV;
               cnt_in   = '0;
            end
         end
         ST_DIV: begin
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               state_in = ST_ROOT_INIT;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_ROOT_INIT: begin
            cnt_in   = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (cnt_ff == CNT_W'(DEV_W - 1)) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         ST_SCAN: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_idx = cnt_ff[ADDR_W-1:0];
         end
         ST_DRAIN: begin
            cmd.mul_load_a = !status.pipe_busy;
         end
         ST_MUL_A: begin
            cmd.mul_step   = !status.mul_done;
            cmd.mul_load_b = status.mul_done;
         end
         ST_MUL_B: begin
            cmd.mul_step = !status.mul_done;
            cmd.div_load = status.mul_done;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_ROOT_INIT: begin
            cmd.sqrt_load = 1'b1;
         end
         ST_ROOT: begin
            cmd.sqrt_step = 1'b1;
         end
         ST_DONE: begin
            cmd.out_load = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end
endmodule

// File: rtl/core/rssd_datapath.sv
// Window store, sums, serial multiply, divide and square root, result register.
`timescale 1ns / 1ps
module rssd_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [rssd_pkg::LEN_W-1:0]        window_length,
   input  logic [rssd_pkg::SAMPLE_WIDTH-1:0] sample_value,
   input  logic                              sample_valid,
   input  logic                              series_start,
   input  rssd_pkg::rssd_cmd_type            cmd,
   output rssd_pkg::rssd_status_type         status,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rssd_pkg::DEV_W-1:0]        deviation_value,
   output logic                              result_valid
);
   import rssd_pkg::*;

   logic [ADDR_W-1:0]       slot_ff, last_ff;
   logic [LEN_W-1:0]        seen_ff, seen_base, seen_in;
   logic [LEN_W-1:0]        n_ff, n_in;
   logic                    enough_ff;
   logic [ADDR_W:0]         rd_sum;
   logic [ADDR_W-1:0]       rd_addr;
   logic [RAM_W-1:0]        rd_data;
   logic [SAMPLE_WIDTH-1:0] rd_x;
   logic signed [SQ_W-1:0]  rd_wide;
   logic [SQ_W-1:0]         sq_c;
   logic                    v1_ff, v2_ff;
   logic [SQ_W-1:0]         sq_ff;
   logic [SAMPLE_WIDTH-1:0] x_ff;
   logic                    ok_ff, all_ok_ff;
   logic signed [S1_W-1:0]  s1_ff;
   logic [S1_W-1:0]         s1_abs;
   logic [S2_W-1:0]         s2_ff;
   logic [NUM_W-1:0]        mcand_ff, prod_ff, p1_ff;
   logic [S1_W-1:0]         mplier_ff;
   logic [NUM_W-1:0]        num_ff;
   logic [D_W-1:0]          dvs_ff, rem_ff;
   logic [D_W:0]            rem_sh;
   logic                    sat_ff;
   logic [RAD_W-1:0]        rad_ff;
   logic [DEV_W+1:0]        srem_ff, srem_sh, trial;
   logic [DEV_W-1:0]        root_ff;
   logic                    rsp_valid_ff, res_valid_ff;
   logic [DEV_W-1:0]        dev_ff;

   always_comb begin
      if (window_length < LEN_W'(2)) begin
         n_in = LEN_W'(2);
      end else if (window_length > LEN_W'(WINDOW_MAX)) begin
         n_in = LEN_W'(WINDOW_MAX);
      end else begin
         n_in = window_length;
      end
      seen_base = series_start ? '0 : seen_ff;
      seen_in   = (seen_base < LEN_W'(WINDOW_MAX)) ? seen_base + LEN_W'(1) : seen_base;
      if (last_ff >= cmd.rd_idx) begin
         rd_sum = {1'b0, last_ff} - {1'b0, cmd.rd_idx};
      end else begin
         rd_sum = {1'b0, last_ff} + (ADDR_W+1)'(WINDOW_MAX) - {1'b0, cmd.rd_idx};
      end
      rd_addr = rd_sum[ADDR_W-1:0];
   end

   rssd_ram #(
      .WIDTH (RAM_W),
      .DEPTH (WINDOW_MAX)
   ) u_window (
      .clock (clock),
      .we    (cmd.start),
      .waddr (slot_ff),
      .wdata ({sample_valid, sample_value}),
      .re    (cmd.rd_en),
      .raddr (rd_addr),
      .rdata (rd_data)
   );

   assign rd_x    = rd_data[SAMPLE_WIDTH-1:0];
   assign rd_wide = $signed({{(SQ_W-SAMPLE_WIDTH){rd_x[SAMPLE_WIDTH-1]}}, rd_x});
   assign sq_c    = SQ_W'(rd_wide * rd_wide);
   assign s1_abs  = s1_ff[S1_W-1] ? S1_W'(-s1_ff) : S1_W'(s1_ff);
   assign rem_sh  = {rem_ff, num_ff[NUM_W-1]};
   assign srem_sh = {srem_ff[DEV_W-1:0], rad_ff[RAD_W-1:RAD_W-2]};
   assign trial   = {root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         seen_ff      <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.start) begin
            slot_ff <= (slot_ff == ADDR_W'(WINDOW_MAX - 1)) ? '0 : slot_ff + ADDR_W'(1);
            seen_ff <= seen_in;
         end
         v1_ff <= cmd.rd_en;
         v2_ff <= v1_ff;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         last_ff   <= slot_ff;
         n_ff      <= n_in;
         enough_ff <= seen_in >= n_in;
         s1_ff     <= '0;
         s2_ff     <= '0;
         all_ok_ff <= 1'b1;
      end else if (v2_ff) begin
         s1_ff     <= s1_ff + $signed({{(S1_W-SAMPLE_WIDTH){x_ff[SAMPLE_WIDTH-1]}}, x_ff});
         s2_ff     <= s2_ff + {{(S2_W-SQ_W){1'b0}}, sq_ff};
         all_ok_ff <= all_ok_ff & ok_ff;
      end
      if (v1_ff) begin
         sq_ff <= sq_c;
         x_ff  <= rd_x;
         ok_ff <= rd_data[SAMPLE_WIDTH];
      end

      if (cmd.mul_load_a) begin
         mcand_ff  <= {{(NUM_W-S2_W){1'b0}}, s2_ff};
         mplier_ff <= {{(S1_W-LEN_W){1'b0}}, n_ff};
         prod_ff   <= '0;
      end else if (cmd.mul_load_b) begin
         p1_ff     <= prod_ff;
         mcand_ff  <= {{(NUM_W-S1_W){1'b0}}, s1_abs};
         mplier_ff <= s1_abs;
         prod_ff   <= '0;
      end else if (cmd.mul_step) begin
         if (mplier_ff[0]) begin
            prod_ff <= prod_ff + mcand_ff;
         end
         mcand_ff  <= {mcand_ff[NUM_W-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[S1_W-1:1]};
      end

      if (cmd.div_load) begin
         num_ff <= p1_ff - prod_ff;
         rem_ff <= '0;
         dvs_ff <= D_W'(n_ff) * (D_W'(n_ff) - D_W'(1));
      end else if (cmd.div_step) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_ff <= D_W'(rem_sh - {1'b0, dvs_ff});
            num_ff <= {num_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[D_W-1:0];
            num_ff <= {num_ff[NUM_W-2:0], 1'b0};
         end
      end

      if (cmd.sqrt_load) begin
         sat_ff  <= |num_ff[NUM_W-1:RAD_W];
         rad_ff  <= num_ff[RAD_W-1:0];
         srem_ff <= '0;
         root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         rad_ff <= {rad_ff[RAD_W-3:0], 2'b00};
         if (srem_sh >= trial) begin
            srem_ff <= srem_sh - trial;
            root_ff <= {root_ff[DEV_W-2:0], 1'b1};
         end else begin
            srem_ff <= srem_sh;
            root_ff <= {root_ff[DEV_W-2:0], 1'b0};
         end
      end

      if (cmd.out_load) begin
         res_valid_ff <= enough_ff & all_ok_ff;
         if (enough_ff && all_ok_ff) begin
            dev_ff <= sat_ff ? '1 : root_ff;
         end else begin
            dev_ff <= '0;
         end
      end
   end

   assign status.enough    = enough_ff;
   assign status.pipe_busy = v1_ff | v2_ff;
   assign status.mul_done  = mplier_ff == '0;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign status.len       = n_ff;

   assign rsp_valid       = rsp_valid_ff;
   assign deviation_value = dev_ff;
   assign result_valid    = res_valid_ff;
endmodule

// File: sim/tb_rolling_sample_std_dev.sv
// Testbench for the rolling sample standard deviation block, self-checking.
`timescale 1ns / 1ps
module tb_rolling_sample_std_dev;
   import rssd_pkg::*;

   typedef struct {
      logic [DEV_W-1:0] deviation;
      logic             dev_ok;
   } dev_word_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   rssd_req_if req_chan ();
   rssd_rsp_if rsp_chan ();

   rolling_sample_std_dev u_dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // window state mirrored here
   logic signed [SAMPLE_WIDTH-1:0] hist_value [WINDOW_MAX];
   bit                             hist_ok [WINDOW_MAX];
   int unsigned                    next_slot;
   int unsigned                    seen_count;
   logic [LEN_W-1:0]               length_reg;

   dev_word_type expected_devs[$];
   int  mismatches;
   bit  quiet;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(80_000_000);
      $display("tb: failure");
      $finish;
   end

   function automatic logic [31:0] isqrt64(logic [63:0] v);
      logic [31:0] root;
      logic [31:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (32'd1 << b);
         if (64'(trial) * 64'(trial) <= v)
            root = trial;
      end
      return root;
   endfunction

   // stores the word and works out the deviation of the last N samples
   function automatic dev_word_type push_and_measure(logic [31:0] value, bit ok, bit start);
      dev_word_type res;
      int unsigned n, last, ia, ib;
      logic [127:0] pair_sum, quot, dsq;
      logic signed [33:0] diff;
      bit good;
      if (start) seen_count = 0;
      hist_value[next_slot] = value;
      hist_ok[next_slot] = ok;
      last = next_slot;
      next_slot = (next_slot + 1) % WINDOW_MAX;
      if (seen_count < WINDOW_MAX) seen_count++;
      n = length_reg;
      if (n < 2) n = 2;
      if (n > WINDOW_MAX) n = WINDOW_MAX;
      good = seen_count >= n;
      for (int i = 0; good && i < n; i++)
         if (!hist_ok[(last + WINDOW_MAX - i) % WINDOW_MAX]) good = 0;
      res.deviation = '0;
      res.dev_ok = good;
      if (good) begin
         pair_sum = '0;
         for (int i = 0; i < n; i++) begin
            ia = (last + WINDOW_MAX - i) % WINDOW_MAX;
            for (int j = i + 1; j < n; j++) begin
               ib = (last + WINDOW_MAX - j) % WINDOW_MAX;
               diff = 34'(hist_value[ia]) - 34'(hist_value[ib]);
               if (diff < 0) diff = -diff;
               dsq = 128'(diff) * 128'(diff);
               pair_sum += dsq;
            end
         end
         quot = pair_sum / 128'(n * (n - 1));
         if (quot[127:64] != 0) res.deviation = '1;
         else res.deviation = isqrt64(quot[63:0]);
      end
      return res;
   endfunction

   task automatic send_sample(logic [31:0] value, bit ok, bit start);
      dev_word_type exp_word;
      @(negedge clock);
      while (!quiet && $urandom_range(0, 99) < 6) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.sample_value = value;
      req_chan.sample_valid = ok;
      req_chan.series_start = start;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      exp_word = push_and_measure(value, ok, start);
      expected_devs.push_back(exp_word);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (expected_devs.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_length(logic [31:0] value);
      @(negedge clock);
      csr_psel = 1'b1; csr_pwrite = 1'b1; csr_penable = 1'b0;
      csr_paddr = CSR_ADDR_W'(REG_WINDOW_LENGTH * 4);
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      length_reg = value[LEN_W-1:0];
      @(negedge clock);
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      dev_word_type exp_word;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_devs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word dev=%h ok=%b",
               rsp_chan.deviation_value, rsp_chan.result_valid);
         end else begin
            exp_word = expected_devs.pop_front();
            if (rsp_chan.deviation_value !== exp_word.deviation ||
                rsp_chan.result_valid !== exp_word.dev_ok) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp dev=%h ok=%b got dev=%h ok=%b",
                     exp_word.deviation, exp_word.dev_ok,
                     rsp_chan.deviation_value, rsp_chan.result_valid);
            end
         end
      end
   end

   initial begin
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         rsp_chan.ready = quiet || ($urandom_range(0, 99) >= 6);
         @(negedge clock);
      end
   end

   task automatic test_short_window();
      write_length(2);
      send_sample(32'h0001_0000, 1, 1);
      send_sample(32'h0003_0000, 1, 0);
      send_sample(32'h0003_0000, 1, 0);
      send_sample(32'h1234_5678, 0, 0);
      send_sample(32'h0002_8000, 1, 0);
      send_sample(32'hFFFF_0000, 1, 0);
      send_sample(32'h0000_0005, 1, 1);
      send_sample(32'h0000_0007, 1, 0);
      wait_drained();
   endtask

   task automatic test_extremes();
      write_length(3);
      send_sample(32'h7FFF_FFFF, 1, 1);
      send_sample(32'h8000_0000, 1, 0);
      send_sample(32'h7FFF_FFFF, 1, 0);
      send_sample(32'h8000_0000, 1, 0);
      send_sample(32'h0000_0000, 1, 0);
      send_sample(32'hFFFF_FFFF, 1, 0);
      wait_drained();
      write_length(0);
      send_sample(32'h8000_0000, 1, 0);
      send_sample(32'h7FFF_FFFF, 1, 0);
      wait_drained();
      write_length(1);
      send_sample(32'h0000_0001, 1, 0);
      wait_drained();
   endtask

   task automatic test_default_length();
      for (int i = 0; i < 22; i++)
         send_sample($urandom_range(0, 32'h0004_0000), 1, i == 0);
      wait_drained();
   endtask

   task automatic test_random_series(logic [31:0] len, int count);
      logic [31:0] base, value;
      int pick;
      write_length(len);
      base = $urandom;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) value = $urandom;
         else if (pick < 80) value = base + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
         else if (pick < 90) value = base;
         else value = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         send_sample(value, $urandom_range(0, 99) >= 3, $urandom_range(0, 99) < 2);
      end
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      quiet = 1'b0;
      mismatches = 0;
      req_chan.valid = 1'b0;
      req_chan.sample_value = '0;
      req_chan.sample_valid = 1'b0;
      req_chan.series_start = 1'b0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      length_reg = WINDOW_LENGTH_RESET;
      next_slot = 0;
      seen_count = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_default_length();
      test_short_window();
      test_extremes();
      test_random_series(64, 230);
      test_random_series(127, 150);
      test_random_series(65, 150);
      quiet = 1'b1;
      test_random_series(4, 250);
      quiet = 1'b0;
      test_random_series(2, 250);
      test_random_series($urandom_range(2, 64), 250);
      test_random_series(20, 250);
      test_random_series($urandom_range(5, 12), 250);

      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: rolling_sample_std_dev.f
rtl/core/rssd_pkg.sv
rtl/core/rssd_chan_if.sv
rtl/core/rssd_ram.sv
rtl/core/rssd_ctrl.sv
rtl/core/rssd_datapath.sv
rtl/core/rolling_sample_std_dev.sv
sim/tb_rolling_sample_std_dev.sv
